// File: rtl/c8x_pkg.sv
package c8x_pkg;

	localparam int STACK_ENTRIES = 16;
	localparam int MEMORY_BYTES  = 4096;
	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;

	localparam int MEM_AW = $clog2(MEMORY_BYTES);
	localparam int SCR_AW = $clog2(SCREEN_HEIGHT);
	localparam int COL_AW = $clog2(SCREEN_WIDTH);
	localparam int STK_AW = $clog2(STACK_ENTRIES);
	localparam int STK_DW = $clog2(STACK_ENTRIES + 1);

	localparam logic [11:0] FONT_BASE_RESET = 12'd80;
	localparam logic [11:0] PC_RESET        = 12'd512;

	// configuration register addresses
	localparam logic [1:0] REG_FONT_BASE = 2'd0;

	// host request codes
	localparam logic [1:0] OP_EXEC     = 2'd0;
	localparam logic [1:0] OP_MEM_WR   = 2'd1;
	localparam logic [1:0] OP_MEM_RD   = 2'd2;
	localparam logic [1:0] OP_PIXEL_RD = 2'd3;

	// fault codes
	localparam logic [1:0] FAULT_NONE       = 2'd0;
	localparam logic [1:0] FAULT_STACK_FULL = 2'd1;
	localparam logic [1:0] FAULT_STACK_EMPTY = 2'd2;

	// instruction groups (top nibble)
	localparam logic [3:0] GRP_SYS   = 4'h0;
	localparam logic [3:0] GRP_JP    = 4'h1;
	localparam logic [3:0] GRP_CALL  = 4'h2;
	localparam logic [3:0] GRP_SEQI  = 4'h3;
	localparam logic [3:0] GRP_SNEI  = 4'h4;
	localparam logic [3:0] GRP_SEQR  = 4'h5;
	localparam logic [3:0] GRP_LDI   = 4'h6;
	localparam logic [3:0] GRP_ADDI  = 4'h7;
	localparam logic [3:0] GRP_ALU   = 4'h8;
	localparam logic [3:0] GRP_SNER  = 4'h9;
	localparam logic [3:0] GRP_LDIDX = 4'hA;
	localparam logic [3:0] GRP_JPV0  = 4'hB;
	localparam logic [3:0] GRP_RND   = 4'hC;
	localparam logic [3:0] GRP_DRAW  = 4'hD;
	localparam logic [3:0] GRP_KEY   = 4'hE;
	localparam logic [3:0] GRP_FN    = 4'hF;

	localparam logic [15:0] INS_CLS = 16'h00E0;
	localparam logic [15:0] INS_RET = 16'h00EE;

	localparam logic [7:0] KEY_DOWN = 8'h9E;
	localparam logic [7:0] KEY_UP   = 8'hA1;

	localparam logic [7:0] FN_GET_DELAY = 8'h07;
	localparam logic [7:0] FN_WAIT_KEY  = 8'h0A;
	localparam logic [7:0] FN_SET_DELAY = 8'h15;
	localparam logic [7:0] FN_SET_SOUND = 8'h18;
	localparam logic [7:0] FN_ADD_IDX   = 8'h1E;
	localparam logic [7:0] FN_FONT      = 8'h29;
	localparam logic [7:0] FN_BCD       = 8'h33;
	localparam logic [7:0] FN_STORE     = 8'h55;
	localparam logic [7:0] FN_LOAD      = 8'h65;

	// 8XYN functions
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	localparam logic [3:0] FLAG_REG = 4'hF;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] instruction;
		logic [11:0] address;
		logic [7:0]  write_data;
		logic [15:0] key_state;
		logic [7:0]  random_byte;
		logic [7:0]  delay_now;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [11:0] program_counter;
		logic [1:0]  fault_code;
		logic        delay_write;
		logic        sound_write;
		logic [7:0]  timer_value;
		logic        waiting_for_key;
		logic        display_changed;
	} rsp_t;

	typedef struct packed {
		logic       wr_x;
		logic [7:0] value;
		logic       wr_f;
		logic [7:0] flag;
	} alu_res_t;

	// split an 8-bit value into hundreds, tens and ones
	function automatic logic [11:0] c8x_bcd(input logic [7:0] v);
		logic [3:0]  h;
		logic [6:0]  rem;
		logic [14:0] prod;
		logic [3:0]  t;
		logic [6:0]  o;
		begin
			if (v >= 8'd200) begin
				h = 4'd2;
				rem = 7'(v - 8'd200);
			end else if (v >= 8'd100) begin
				h = 4'd1;
				rem = 7'(v - 8'd100);
			end else begin
				h = 4'd0;
				rem = v[6:0];
			end
			// rem / 10 via reciprocal, exact for rem below 100
			prod = 15'(rem) * 15'd205;
			t = prod[14:11];
			o = 7'(rem - 7'(t) * 7'd10);
			return {h, t, o[3:0]};
		end
	endfunction

endpackage

// File: rtl/c8x_alu.sv
module c8x_alu (
	input  logic [3:0]         funct,
	input  logic [7:0]         vx,
	input  logic [7:0]         vy,
	output c8x_pkg::alu_res_t  res
);
	import c8x_pkg::*;

	logic [8:0] sum;

	assign sum = {1'b0, vx} + {1'b0, vy};

	// compute the register result and the flag of an 8XYN operation
	always_comb begin
		res = '0;
		case (funct)
			ALU_MOV: begin
				res.wr_x = 1'b1;
				res.value = vy;
			end
			ALU_OR: begin
				res.wr_x = 1'b1;
				res.value = vx | vy;
				res.wr_f = 1'b1;
			end
			ALU_AND: begin
				res.wr_x = 1'b1;
				res.value = vx & vy;
				res.wr_f = 1'b1;
			end
			ALU_XOR: begin
				res.wr_x = 1'b1;
				res.value = vx ^ vy;
				res.wr_f = 1'b1;
			end
			ALU_ADD: begin
				res.wr_x = 1'b1;
				res.value = sum[7:0];
				res.wr_f = 1'b1;
				res.flag = {7'd0, sum[8]};
			end
			ALU_SUB: begin
				res.wr_x = 1'b1;
				res.value = vx - vy;
				res.wr_f = 1'b1;
				res.flag = {7'd0, vx >= vy};
			end
			ALU_SHR: begin
				res.wr_x = 1'b1;
				res.value = {1'b0, vy[7:1]};
				res.wr_f = 1'b1;
				res.flag = {7'd0, vy[0]};
			end
			ALU_SUBN: begin
				res.wr_x = 1'b1;
				res.value = vy - vx;
				res.wr_f = 1'b1;
				res.flag = {7'd0, vy >= vx};
			end
			ALU_SHL: begin
				res.wr_x = 1'b1;
				res.value = {vy[6:0], 1'b0};
				res.wr_f = 1'b1;
				res.flag = {7'd0, vy[7]};
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

// File: rtl/chip8_instruction_execute.sv
// CHIP-8 execute unit: one request is taken when the unit is idle.
// Steps: two register-file reads (S_RDX, S_RDY), execute (S_EXEC) and
// result load (S_DONE); 8XYN that set VF add S_WRF, a sprite draw runs
// S_DMEM/S_DROW per row then S_WRF, FX55/FX65 run S_SVRD/S_SMWR or
// S_LMRD/S_LVWR per register and FX33 runs S_BCD per digit.
// A new request is taken the cycle after the result enters the output register.
// Reset: PC 512, I 0, stack empty, V0-VF and display read as zero, font at 80.
module chip8_instruction_execute (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  c8x_pkg::req_t       in_req,
	output logic                out_valid,
	input  logic                out_ready,
	output c8x_pkg::rsp_t       out_rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import c8x_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RDX, S_RDY, S_EXEC, S_WRF, S_DMEM, S_DROW,
		S_BCD, S_SVRD, S_SMWR, S_LMRD, S_LVWR, S_DONE
	} state_t;

	state_t state_q;
	req_t   req_q;
	rsp_t   out_rsp_q;
	logic   out_valid_q;

	logic [11:0]       font_base_q;
	logic [11:0]       pc_q;
	logic [15:0]       i_q;
	logic [STK_DW-1:0] depth_q;
	logic [7:0]        vx_q;
	logic [4:0]        cnt_q;
	logic [SCR_AW-1:0] yp_q;
	logic [COL_AW-1:0] xp_q;
	logic [7:0]        f_q;
	logic              coll_q;
	logic              chg_q;
	logic [7:0]        rdata_q;
	logic [1:0]        fault_q;
	logic              dwr_q;
	logic              swr_q;
	logic [7:0]        tval_q;
	logic              wait_q;

	// memories and read registers
	logic [7:0]               mem [MEMORY_BYTES];
	logic [7:0]               mem_rd_q;
	logic [SCREEN_WIDTH-1:0]  scr_mem [SCREEN_HEIGHT];
	logic [SCREEN_WIDTH-1:0]  scr_rd_q;
	logic [SCREEN_HEIGHT-1:0] scr_vld_q;
	logic [SCREEN_HEIGHT-1:0] scr_nz_q;
	logic                     scr_rvld_q;
	logic [7:0]               v_mem [16];
	logic [7:0]               v_rd_q;
	logic [15:0]              v_vld_q;
	logic                     v_rvld_q;
	logic [11:0]              stk_mem [STACK_ENTRIES];
	logic [11:0]              stk_rd_q;

	logic [MEM_AW-1:0] mem_raddr, mem_waddr;
	logic              mem_we;
	logic [7:0]        mem_wdata;
	logic [SCR_AW-1:0] scr_raddr, scr_waddr;
	logic              scr_we;
	logic [3:0]        v_raddr, v_waddr;
	logic              v_we;
	logic [7:0]        v_wdata;
	logic [STK_AW-1:0] stk_raddr;
	logic              stk_we;

	// decoded fields
	logic [3:0]  grp, fx, fy, fn;
	logic [7:0]  nn;
	logic [11:0] nnn;
	logic [7:0]  vread, vy;
	logic [11:0] pc_inc, pc_nxt;
	logic [1:0]  fault_nxt;
	logic        wait_nxt;
	logic        key_hit;
	logic [3:0]  key_idx;
	logic        full, empty;
	alu_res_t    alu_res;
	logic [11:0] bcd;
	logic [11:0] i_off;

	// draw datapath
	logic [7:0]              spr_rev;
	logic [SCREEN_WIDTH-1:0] row_old, row_mask, row_new;
	logic                    row_hit;
	logic [4:0]              cnt_nxt;
	logic [5:0]              row_nxt;
	logic                    draw_more;

	assign grp = req_q.instruction[15:12];
	assign fx  = req_q.instruction[11:8];
	assign fy  = req_q.instruction[7:4];
	assign fn  = req_q.instruction[3:0];
	assign nn  = req_q.instruction[7:0];
	assign nnn = req_q.instruction[11:0];

	assign vread  = v_rvld_q ? v_rd_q : 8'd0;
	assign vy     = vread;
	assign pc_inc = pc_q + 12'd2;
	assign full   = (depth_q >= STK_DW'(STACK_ENTRIES));
	assign empty  = (depth_q == '0);
	assign bcd    = c8x_bcd(vx_q);
	assign i_off  = i_q[11:0] + {7'd0, cnt_q};

	c8x_alu u_alu (
		.funct (fn),
		.vx    (vx_q),
		.vy    (vy),
		.res   (alu_res)
	);

	// lowest pressed key
	always_comb begin
		key_idx = 4'd0;
		for (int k = 15; k >= 0; k--) begin
			if (req_q.key_state[k]) begin
				key_idx = 4'(k);
			end
		end
	end
	assign key_hit = (req_q.key_state != 16'd0);

	// sprite row against the display row
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			spr_rev[b] = mem_rd_q[7 - b];
		end
	end
	assign row_old   = scr_rvld_q ? scr_rd_q : '0;
	assign row_mask  = SCREEN_WIDTH'(spr_rev) << xp_q;
	assign row_new   = row_old ^ row_mask;
	assign row_hit   = |(row_old & row_mask);
	assign cnt_nxt   = cnt_q + 5'd1;
	assign row_nxt   = {1'b0, yp_q} + {1'b0, cnt_nxt};
	assign draw_more = (cnt_nxt < {1'b0, fn}) && (row_nxt < 6'(SCREEN_HEIGHT));

	// next PC and faults of a branch-type instruction
	always_comb begin
		pc_nxt = pc_inc;
		fault_nxt = FAULT_NONE;
		wait_nxt = 1'b0;
		case (grp)
			GRP_SYS: begin
				if (req_q.instruction == INS_RET) begin
					if (empty) begin
						fault_nxt = FAULT_STACK_EMPTY;
					end else begin
						pc_nxt = stk_rd_q;
					end
				end
			end
			GRP_JP: pc_nxt = nnn;
			GRP_CALL: begin
				if (full) begin
					pc_nxt = pc_q;
					fault_nxt = FAULT_STACK_FULL;
				end else begin
					pc_nxt = nnn;
				end
			end
			GRP_SEQI: if (vx_q == nn) pc_nxt = pc_inc + 12'd2;
			GRP_SNEI: if (vx_q != nn) pc_nxt = pc_inc + 12'd2;
			GRP_SEQR: if (vx_q == vy) pc_nxt = pc_inc + 12'd2;
			GRP_SNER: if (vx_q != vy) pc_nxt = pc_inc + 12'd2;
			GRP_JPV0: pc_nxt = nnn + {4'd0, vx_q};
			GRP_KEY: begin
				if ((nn == KEY_DOWN && req_q.key_state[vx_q[3:0]]) ||
				    (nn == KEY_UP && !req_q.key_state[vx_q[3:0]])) begin
					pc_nxt = pc_inc + 12'd2;
				end
			end
			default: begin
				if (grp == GRP_FN && nn == FN_WAIT_KEY && !key_hit) begin
					pc_nxt = pc_q;
					wait_nxt = 1'b1;
				end
			end
		endcase
	end

	// read addresses
	always_comb begin
		case (state_q)
			S_RDX:   v_raddr = (grp == GRP_JPV0) ? 4'd0 : fx;
			S_RDY:   v_raddr = fy;
			S_SVRD:  v_raddr = cnt_q[3:0];
			default: v_raddr = fx;
		endcase
		mem_raddr = (state_q == S_DMEM || state_q == S_LMRD) ? i_off : req_q.address;
		scr_raddr = (state_q == S_DMEM) ? SCR_AW'({1'b0, yp_q} + {1'b0, cnt_q}) :
		            req_q.address[COL_AW +: SCR_AW];
		stk_raddr = STK_AW'(depth_q - STK_DW'(1));
	end

	// write ports
	always_comb begin
		v_we = 1'b0;
		v_waddr = fx;
		v_wdata = 8'd0;
		mem_we = 1'b0;
		mem_waddr = i_off;
		mem_wdata = 8'd0;
		scr_we = 1'b0;
		scr_waddr = SCR_AW'({1'b0, yp_q} + {1'b0, cnt_q});
		stk_we = 1'b0;
		case (state_q)
			S_EXEC: begin
				if (req_q.op == OP_MEM_WR) begin
					mem_we = 1'b1;
					mem_waddr = req_q.address;
					mem_wdata = req_q.write_data;
				end else if (req_q.op == OP_EXEC) begin
					case (grp)
						GRP_CALL: stk_we = !full;
						GRP_LDI: begin
							v_we = 1'b1;
							v_wdata = nn;
						end
						GRP_ADDI: begin
							v_we = 1'b1;
							v_wdata = vx_q + nn;
						end
						GRP_ALU: begin
							v_we = alu_res.wr_x;
							v_wdata = alu_res.value;
						end
						GRP_RND: begin
							v_we = 1'b1;
							v_wdata = req_q.random_byte & nn;
						end
						GRP_FN: begin
							if (nn == FN_GET_DELAY) begin
								v_we = 1'b1;
								v_wdata = req_q.delay_now;
							end else if (nn == FN_WAIT_KEY) begin
								v_we = key_hit;
								v_wdata = {4'd0, key_idx};
							end
						end
						default: v_we = 1'b0;
					endcase
				end
			end
			S_WRF: begin
				v_we = 1'b1;
				v_waddr = FLAG_REG;
				v_wdata = f_q;
			end
			S_DROW: scr_we = 1'b1;
			S_BCD: begin
				mem_we = 1'b1;
				case (cnt_q[1:0])
					2'd0:    mem_wdata = {4'd0, bcd[11:8]};
					2'd1:    mem_wdata = {4'd0, bcd[7:4]};
					default: mem_wdata = {4'd0, bcd[3:0]};
				endcase
			end
			S_SMWR: begin
				mem_we = 1'b1;
				mem_wdata = vread;
			end
			S_LVWR: begin
				v_we = 1'b1;
				v_waddr = cnt_q[3:0];
				v_wdata = mem_rd_q;
			end
			default: v_we = 1'b0;
		endcase
	end

	// main memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rd_q <= mem[mem_raddr];
	end

	// display rows, register file and stack
	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_mem[scr_waddr] <= row_new;
		end
		scr_rd_q <= scr_mem[scr_raddr];
		if (v_we) begin
			v_mem[v_waddr] <= v_wdata;
		end
		v_rd_q <= v_mem[v_raddr];
		if (stk_we) begin
			stk_mem[depth_q[STK_AW-1:0]] <= pc_inc;
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	// valid bits of the register file and display rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_vld_q <= '0;
			v_rvld_q <= 1'b0;
			scr_vld_q <= '0;
			scr_nz_q <= '0;
			scr_rvld_q <= 1'b0;
		end else begin
			v_rvld_q <= v_vld_q[v_raddr];
			scr_rvld_q <= scr_vld_q[scr_raddr];
			if (v_we) begin
				v_vld_q[v_waddr] <= 1'b1;
			end
			if (scr_we) begin
				scr_vld_q[scr_waddr] <= 1'b1;
				scr_nz_q[scr_waddr] <= |row_new;
			end
			if (state_q == S_EXEC && req_q.op == OP_EXEC &&
			    req_q.instruction == INS_CLS) begin
				scr_vld_q <= '0;
				scr_nz_q <= '0;
			end
		end
	end

	// sequencer, architectural registers and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			out_rsp_q <= '0;
			out_valid_q <= 1'b0;
			font_base_q <= FONT_BASE_RESET;
			pc_q <= PC_RESET;
			i_q <= '0;
			depth_q <= '0;
			vx_q <= '0;
			cnt_q <= '0;
			yp_q <= '0;
			xp_q <= '0;
			f_q <= '0;
			coll_q <= 1'b0;
			chg_q <= 1'b0;
			rdata_q <= '0;
			fault_q <= FAULT_NONE;
			dwr_q <= 1'b0;
			swr_q <= 1'b0;
			tval_q <= '0;
			wait_q <= 1'b0;
		end else begin
			// take configuration writes
			if (psel && penable && pwrite && paddr == REG_FONT_BASE) begin
				font_base_q <= pwdata[11:0];
			end
			// drop delivered result
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_req;
						rdata_q <= '0;
						fault_q <= FAULT_NONE;
						dwr_q <= 1'b0;
						swr_q <= 1'b0;
						tval_q <= '0;
						wait_q <= 1'b0;
						chg_q <= 1'b0;
						state_q <= S_RDX;
					end
				end
				S_RDX: state_q <= S_RDY;
				S_RDY: begin
					vx_q <= vread;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_DONE;
					cnt_q <= '0;
					if (req_q.op == OP_MEM_RD) begin
						rdata_q <= mem_rd_q;
					end else if (req_q.op == OP_PIXEL_RD) begin
						rdata_q <= {7'd0, !req_q.address[11] && scr_rvld_q &&
						            scr_rd_q[req_q.address[COL_AW-1:0]]};
					end else if (req_q.op == OP_EXEC) begin
						pc_q <= pc_nxt;
						fault_q <= fault_nxt;
						wait_q <= wait_nxt;
						case (grp)
							GRP_SYS: begin
								if (req_q.instruction == INS_CLS) begin
									chg_q <= |scr_nz_q;
								end else if (req_q.instruction == INS_RET && !empty) begin
									depth_q <= depth_q - STK_DW'(1);
								end
							end
							GRP_CALL: if (!full) depth_q <= depth_q + STK_DW'(1);
							GRP_ALU: begin
								if (alu_res.wr_f) begin
									f_q <= alu_res.flag;
									state_q <= S_WRF;
								end
							end
							GRP_LDIDX: i_q <= {4'd0, nnn};
							GRP_DRAW: begin
								xp_q <= vx_q[COL_AW-1:0];
								yp_q <= vy[SCR_AW-1:0];
								coll_q <= 1'b0;
								f_q <= '0;
								state_q <= (fn == 4'd0) ? S_WRF : S_DMEM;
							end
							GRP_FN: begin
								case (nn)
									FN_SET_DELAY: begin
										dwr_q <= 1'b1;
										tval_q <= vx_q;
									end
									FN_SET_SOUND: begin
										swr_q <= 1'b1;
										tval_q <= vx_q;
									end
									FN_ADD_IDX: i_q <= i_q + {8'd0, vx_q};
									FN_FONT: i_q <= {4'd0, font_base_q} +
									               16'({vx_q[3:0], 2'b00}) + {12'd0, vx_q[3:0]};
									FN_BCD: state_q <= S_BCD;
									FN_STORE: state_q <= S_SVRD;
									FN_LOAD: state_q <= S_LMRD;
									default: state_q <= S_DONE;
								endcase
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_WRF: state_q <= S_DONE;
				S_DMEM: state_q <= S_DROW;
				S_DROW: begin
					chg_q <= chg_q | (|row_mask);
					coll_q <= coll_q | row_hit;
					cnt_q <= cnt_nxt;
					if (draw_more) begin
						state_q <= S_DMEM;
					end else begin
						f_q <= {7'd0, coll_q | row_hit};
						state_q <= S_WRF;
					end
				end
				S_BCD: begin
					cnt_q <= cnt_nxt;
					if (cnt_q == 5'd2) begin
						state_q <= S_DONE;
					end
				end
				S_SVRD: state_q <= S_SMWR;
				S_SMWR: begin
					cnt_q <= cnt_nxt;
					if (cnt_q[3:0] == fx) begin
						i_q <= i_q + {12'd0, fx} + 16'd1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SVRD;
					end
				end
				S_LMRD: state_q <= S_LVWR;
				S_LVWR: begin
					cnt_q <= cnt_nxt;
					if (cnt_q[3:0] == fx) begin
						i_q <= i_q + {12'd0, fx} + 16'd1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_LMRD;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_rsp_q.read_data <= rdata_q;
						out_rsp_q.program_counter <= pc_q;
						out_rsp_q.fault_code <= fault_q;
						out_rsp_q.delay_write <= dwr_q;
						out_rsp_q.sound_write <= swr_q;
						out_rsp_q.timer_value <= tval_q;
						out_rsp_q.waiting_for_key <= wait_q;
						out_rsp_q.display_changed <= chg_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr == REG_FONT_BASE) ? {20'd0, font_base_q} : 32'd0;

endmodule

// File: test/tb_chip8_instruction_execute.sv
module tb_chip8_instruction_execute;
	import c8x_pkg::*;

	localparam int         STALL_LIMIT   = 5000;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         SETTLE_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	req_t        in_req = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	rsp_t        out_rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow machine state
	logic [7:0]  mem_image [MEMORY_BYTES];
	logic [63:0] screen_image [SCREEN_HEIGHT];
	logic [7:0]  vreg [16];
	logic [15:0] idx_reg = '0;
	logic [11:0] pc_reg = PC_RESET;
	logic [11:0] call_stack [STACK_ENTRIES];
	int          call_depth = 0;
	logic [11:0] glyph_base = FONT_BASE_RESET;

	rsp_t pending_results [$];
	int   mismatch_count = 0;
	int   sender_idle_pct = 0;
	int   receiver_stall_pct = 0;
	int   hold_requests = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;

	chip8_instruction_execute u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		for (int i = 0; i < SCREEN_HEIGHT; i++) screen_image[i] = '0;
		for (int i = 0; i < 16; i++) vreg[i] = '0;
		for (int i = 0; i < MEMORY_BYTES; i++) mem_image[i] = '0;
		for (int i = 0; i < STACK_ENTRIES; i++) call_stack[i] = '0;
	end

	// work out the response of one request and advance the shadow state
	function automatic rsp_t execute_request(req_t r);
		rsp_t        o;
		logic [3:0]  x, y, n;
		logic [7:0]  nn, vx, vy, bits;
		logic [11:0] nnn;
		logic [8:0]  sum;
		logic [15:0] a;
		int          xp, yp, k;
		o = '0;
		case (r.op)
			OP_MEM_WR: mem_image[r.address] = r.write_data;
			OP_MEM_RD: o.read_data = mem_image[r.address];
			OP_PIXEL_RD: begin
				if (r.address < SCREEN_WIDTH * SCREEN_HEIGHT)
					o.read_data = {7'd0, screen_image[r.address[10:6]][r.address[5:0]]};
			end
			default: begin
				x = r.instruction[11:8];
				y = r.instruction[7:4];
				n = r.instruction[3:0];
				nn = r.instruction[7:0];
				nnn = r.instruction[11:0];
				vx = vreg[x];
				vy = vreg[y];
				pc_reg = pc_reg + 12'd2;
				case (r.instruction[15:12])
					GRP_SYS: begin
						if (r.instruction == INS_CLS) begin
							for (k = 0; k < SCREEN_HEIGHT; k++) begin
								if (screen_image[k] != '0) o.display_changed = 1'b1;
								screen_image[k] = '0;
							end
						end else if (r.instruction == INS_RET) begin
							if (call_depth > 0) begin
								call_depth--;
								pc_reg = call_stack[call_depth];
							end else begin
								o.fault_code = FAULT_STACK_EMPTY;
							end
						end
					end
					GRP_JP: pc_reg = nnn;
					GRP_CALL: begin
						if (call_depth >= STACK_ENTRIES) begin
							pc_reg = pc_reg - 12'd2;
							o.fault_code = FAULT_STACK_FULL;
						end else begin
							call_stack[call_depth] = pc_reg;
							call_depth++;
							pc_reg = nnn;
						end
					end
					GRP_SEQI: if (vx == nn) pc_reg = pc_reg + 12'd2;
					GRP_SNEI: if (vx != nn) pc_reg = pc_reg + 12'd2;
					GRP_SEQR: if (vx == vy) pc_reg = pc_reg + 12'd2;
					GRP_LDI: vreg[x] = nn;
					GRP_ADDI: vreg[x] = vx + nn;
					GRP_ALU: begin
						case (n)
							ALU_MOV: vreg[x] = vy;
							ALU_OR: begin vreg[x] = vx | vy; vreg[FLAG_REG] = 8'd0; end
							ALU_AND: begin vreg[x] = vx & vy; vreg[FLAG_REG] = 8'd0; end
							ALU_XOR: begin vreg[x] = vx ^ vy; vreg[FLAG_REG] = 8'd0; end
							ALU_ADD: begin
								sum = {1'b0, vx} + {1'b0, vy};
								vreg[x] = sum[7:0];
								vreg[FLAG_REG] = {7'd0, sum[8]};
							end
							ALU_SUB: begin
								vreg[x] = vx - vy;
								vreg[FLAG_REG] = {7'd0, vx >= vy};
							end
							ALU_SHR: begin
								vreg[x] = vy >> 1;
								vreg[FLAG_REG] = {7'd0, vy[0]};
							end
							ALU_SUBN: begin
								vreg[x] = vy - vx;
								vreg[FLAG_REG] = {7'd0, vy >= vx};
							end
							ALU_SHL: begin
								vreg[x] = vy << 1;
								vreg[FLAG_REG] = {7'd0, vy[7]};
							end
							default: ;
						endcase
					end
					GRP_SNER: if (vx != vy) pc_reg = pc_reg + 12'd2;
					GRP_LDIDX: idx_reg = {4'd0, nnn};
					GRP_JPV0: pc_reg = nnn + {4'd0, vreg[0]};
					GRP_RND: vreg[x] = r.random_byte & nn;
					GRP_DRAW: begin
						// clip at the right and bottom edges, flag any erased pixel
						xp = vx[5:0];
						yp = vy[4:0];
						vreg[FLAG_REG] = 8'd0;
						for (int row = 0; row < n; row++) begin
							if (yp + row >= SCREEN_HEIGHT) break;
							a = idx_reg + row[15:0];
							bits = mem_image[a[11:0]];
							for (int col = 0; col < 8; col++) begin
								if (xp + col >= SCREEN_WIDTH) break;
								if (bits[7 - col]) begin
									if (screen_image[yp + row][xp + col])
										vreg[FLAG_REG] = 8'd1;
									screen_image[yp + row][xp + col] =
										~screen_image[yp + row][xp + col];
									o.display_changed = 1'b1;
								end
							end
						end
					end
					GRP_KEY: begin
						if ((nn == KEY_DOWN && r.key_state[vx[3:0]]) ||
						    (nn == KEY_UP && !r.key_state[vx[3:0]]))
							pc_reg = pc_reg + 12'd2;
					end
					default: begin
						case (nn)
							FN_GET_DELAY: vreg[x] = r.delay_now;
							FN_WAIT_KEY: begin
								if (r.key_state == '0) begin
									pc_reg = pc_reg - 12'd2;
									o.waiting_for_key = 1'b1;
								end else begin
									for (k = 0; k < 16; k++) if (r.key_state[k]) break;
									vreg[x] = k[7:0];
								end
							end
							FN_SET_DELAY: begin o.delay_write = 1'b1; o.timer_value = vx; end
							FN_SET_SOUND: begin o.sound_write = 1'b1; o.timer_value = vx; end
							FN_ADD_IDX: idx_reg = idx_reg + {8'd0, vx};
							FN_FONT: idx_reg = {4'd0, glyph_base} + 16'(vx[3:0]) * 16'd5;
							FN_BCD: begin
								a = idx_reg;
								mem_image[a[11:0]] = vx / 100;
								a = idx_reg + 16'd1;
								mem_image[a[11:0]] = (vx / 10) % 10;
								a = idx_reg + 16'd2;
								mem_image[a[11:0]] = vx % 10;
							end
							FN_STORE: begin
								for (k = 0; k <= x; k++) begin
									a = idx_reg + k[15:0];
									mem_image[a[11:0]] = vreg[k];
								end
								idx_reg = idx_reg + {12'd0, x} + 16'd1;
							end
							FN_LOAD: begin
								for (k = 0; k <= x; k++) begin
									a = idx_reg + k[15:0];
									vreg[k] = mem_image[a[11:0]];
								end
								idx_reg = idx_reg + {12'd0, x} + 16'd1;
							end
							default: ;
						endcase
					end
				endcase
			end
		endcase
		o.program_counter = pc_reg;
		return o;
	endfunction

	// predict every accepted request
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			pending_results.push_back(execute_request(in_req));
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// compare each response with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected response: expected none actual %h", $time, out_rsp);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("read_data", want.read_data, out_rsp.read_data);
				check_field("program_counter", want.program_counter, out_rsp.program_counter);
				check_field("fault_code", want.fault_code, out_rsp.fault_code);
				check_field("delay_write", want.delay_write, out_rsp.delay_write);
				check_field("sound_write", want.sound_write, out_rsp.sound_write);
				check_field("timer_value", want.timer_value, out_rsp.timer_value);
				check_field("waiting_for_key", want.waiting_for_key, out_rsp.waiting_for_key);
				check_field("display_changed", want.display_changed, out_rsp.display_changed);
			end
		end
	end

	// drive ready: random stalls, or a long hold when one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// abort when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// present one request and hold it until accepted
	task automatic send_request(req_t r);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		in_req <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_font_base(logic [11:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_FONT_BASE;
		pwdata <= {20'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		glyph_base = value;
	endtask

	function automatic req_t exec_request(logic [15:0] word, logic [15:0] keys);
		req_t r;
		r.op = OP_EXEC;
		r.instruction = word;
		r.address = 12'($urandom);
		r.write_data = 8'($urandom);
		r.key_state = keys;
		r.random_byte = 8'($urandom);
		r.delay_now = 8'($urandom);
		return r;
	endfunction

	function automatic logic [15:0] random_keys();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'd1 << $urandom_range(15);
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly well-formed instructions, some host access and stray words
	function automatic req_t random_request();
		req_t        r;
		logic [15:0] w;
		logic [3:0]  alu_fn [9];
		logic [7:0]  fn_sel [9];
		alu_fn = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
		           ALU_SUBN, ALU_SHL};
		fn_sel = '{FN_GET_DELAY, FN_WAIT_KEY, FN_SET_DELAY, FN_SET_SOUND, FN_ADD_IDX,
		           FN_FONT, FN_BCD, FN_STORE, FN_LOAD};
		w = 16'($urandom);
		case (w[15:12])
			GRP_SYS: begin
				case ($urandom_range(5))
					0, 1, 2: w = INS_RET;
					3, 4: w = INS_CLS;
					default: ;
				endcase
			end
			GRP_ALU: if ($urandom_range(9) != 0) w[3:0] = alu_fn[$urandom_range(8)];
			GRP_KEY: begin
				if ($urandom_range(9) != 0)
					w[7:0] = $urandom_range(1) ? KEY_DOWN : KEY_UP;
			end
			GRP_FN: if ($urandom_range(9) != 0) w[7:0] = fn_sel[$urandom_range(8)];
			default: ;
		endcase
		r = exec_request(w, random_keys());
		case ($urandom_range(19))
			0, 1: r.op = OP_MEM_WR;
			2: r.op = OP_MEM_RD;
			3: begin
				r.op = OP_PIXEL_RD;
				if ($urandom_range(3) != 0) r.address[11] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// fill all of memory so that no later read sees an unwritten byte:
	// point I at zero, then store all sixteen registers block after block,
	// loading a fresh random byte into one register before each block
	task automatic test_memory_load();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		send_request(exec_request({GRP_LDIDX, 12'd0}, 16'd0));
		for (int b = 0; b < MEMORY_BYTES / 16; b++) begin
			send_request(exec_request({GRP_RND, b[3:0], 8'hFF}, 16'd0));
			send_request(exec_request({GRP_FN, 4'hF, FN_STORE}, 16'd0));
		end
		drain_results();
	endtask

	task automatic test_directed();
		req_t r;
		logic [15:0] words [] = '{
			16'h60FF, 16'h6101, 16'h8014, 16'h60FF, 16'h8F04, 16'h8015, 16'h6280,
			16'h8126, 16'h812E, 16'h8017, 16'h8F25, 16'h3000, 16'h4000, 16'h901F,
			16'h5017, 16'h00EE, 16'h0123, 16'h801F, 16'hE0FF, 16'hF0FF,
			16'h633F, 16'h641F, 16'hA123, 16'hD34F, 16'hD340, 16'hD34F, 16'h00E0,
			16'h00E0, 16'hF333, 16'hFF55, 16'hFF65, 16'hF029, 16'hF015, 16'hF018,
			16'hF007, 16'hBFFF, 16'hC0FF, 16'hE09E, 16'hE0A1, 16'hF01E};
		foreach (words[i]) send_request(exec_request(words[i], random_keys()));
		// wait for key, with none and with only the top key pressed
		send_request(exec_request(16'hF50A, 16'h0000));
		send_request(exec_request(16'hF50A, 16'h8000));
		// fill the stack, then call once more
		for (int i = 0; i <= STACK_ENTRIES; i++)
			send_request(exec_request({GRP_CALL, 12'($urandom)}, 16'd0));
		send_request(exec_request(INS_RET, 16'd0));
		// pixel reads at both ends and past the screen
		r = exec_request(16'd0, 16'd0);
		r.op = OP_PIXEL_RD;
		r.address = 12'd0;
		send_request(r);
		r.address = 12'd2047;
		send_request(r);
		r.address = 12'hFFF;
		send_request(r);
		r.op = OP_MEM_RD;
		send_request(r);
		drain_results();
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) send_request(random_request());
		drain_results();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
	endtask

	// long receiver hold while requests keep coming, then a full pause and two more batches
	task automatic test_backpressure();
		hold_requests++;
		for (int i = 0; i < 60; i++) send_request(random_request());
		drain_results();
		for (int i = 0; i < 40; i++) send_request(random_request());
		drain_results();
		for (int i = 0; i < 40; i++) send_request(random_request());
		drain_results();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_memory_load();
		test_directed();
		write_font_base(12'd0);
		test_random(135, 0, 0);
		write_font_base(12'hFFF);
		test_random(135, 69, 0);
		write_font_base(FONT_BASE_RESET);
		test_random(135, 0, 69);
		write_font_base(12'($urandom));
		test_random(135, 36, 36);
		test_backpressure();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
